// File: rtl/mm4_pkg.sv
// Shared types and constants for the 4x4 fixed-point matrix multiplier.
// Used by mm4_ctrl, mm4_dp, matrix_multiply_4x4_top and tb; no dependencies.
package mm4_pkg;

   localparam int DIM_DEFAULT       = 4;
   localparam int FRAC_BITS_DEFAULT = 16;
   localparam int ELEM_W            = 32;
   localparam int INDEX_W           = 4;

   localparam logic signed [ELEM_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [ELEM_W-1:0] SAT_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic signed [ELEM_W-1:0] left_element;
      logic signed [ELEM_W-1:0] right_element;
      logic [INDEX_W-1:0]       element_index;
      logic                     load_last;
   } req_type;

   typedef struct packed {
      logic signed [ELEM_W-1:0] product_element;
      logic [INDEX_W-1:0]       product_index;
      logic                     run_last;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_START,
      ST_ISSUE,
      ST_DRAIN
   } ctl_state_type;

   // controller -> datapath
   typedef struct packed {
      logic               issue;
      logic               first;
      logic               last;
      logic               res_last;
      logic [INDEX_W-1:0] res_index;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic out_busy;
      logic res_loaded;
   } status_type;

endpackage

// File: rtl/mm4_ctrl.sv
// Sequencer for the matrix multiplier: walks result cells in column-major
// order and issues operand reads. Depends on mm4_pkg.
module mm4_ctrl #(
   parameter int DIM = mm4_pkg::DIM_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  mm4_pkg::status_type         status,
   output logic                        busy,
   output mm4_pkg::cmd_type            cmd,
   output logic [$clog2(DIM*DIM)-1:0]  left_addr,
   output logic [$clog2(DIM*DIM)-1:0]  right_addr
);

   localparam int Cells = DIM * DIM;
   localparam int AW    = $clog2(Cells);
   localparam int EW    = $clog2(DIM);

   mm4_pkg::ctl_state_type state_ff, state_in;

   logic [EW-1:0] step_ff, step_in;
   logic [EW-1:0] row_ff, row_in;
   logic [AW-1:0] col_base_ff, col_base_in;
   logic [AW-1:0] cell_ff, cell_in;
   logic [AW-1:0] laddr_ff, laddr_in;
   logic [AW-1:0] raddr_ff, raddr_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mm4_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff     <= step_in;
      row_ff      <= row_in;
      col_base_ff <= col_base_in;
      cell_ff     <= cell_in;
      laddr_ff    <= laddr_in;
      raddr_ff    <= raddr_in;
   end

   always_comb begin
      state_in    = state_ff;
      step_in     = step_ff;
      row_in      = row_ff;
      col_base_in = col_base_ff;
      cell_in     = cell_ff;
      laddr_in    = laddr_ff;
      raddr_in    = raddr_ff;
      unique case (state_ff)
         mm4_pkg::ST_IDLE: begin
            row_in      = '0;
            col_base_in = '0;
            cell_in     = '0;
            if (start) begin
               state_in = mm4_pkg::ST_START;
            end
         end
         mm4_pkg::ST_START: begin
            step_in  = '0;
            laddr_in = AW'(row_ff);
            raddr_in = col_base_ff;
            if (!status.out_busy) begin
               state_in = mm4_pkg::ST_ISSUE;
            end
         end
         mm4_pkg::ST_ISSUE: begin
            step_in  = step_ff + EW'(1);
            laddr_in = laddr_ff + AW'(DIM);
            raddr_in = raddr_ff + AW'(1);
            if (step_ff == EW'(DIM - 1)) begin
               state_in = mm4_pkg::ST_DRAIN;
            end
         end
         mm4_pkg::ST_DRAIN: begin
            if (status.res_loaded) begin
               cell_in = cell_ff + AW'(1);
               if (row_ff == EW'(DIM - 1)) begin
                  row_in      = '0;
                  col_base_in = col_base_ff + AW'(DIM);
               end else begin
                  row_in = row_ff + EW'(1);
               end
               if (cell_ff == AW'(Cells - 1)) begin
                  state_in = mm4_pkg::ST_IDLE;
               end else begin
                  state_in = mm4_pkg::ST_START;
               end
            end
         end
         default: begin
            state_in = mm4_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy          = (state_ff != mm4_pkg::ST_IDLE);
   assign cmd.issue     = (state_ff == mm4_pkg::ST_ISSUE);
   assign cmd.first     = (step_ff == '0);
   assign cmd.last      = (step_ff == EW'(DIM - 1));
   assign cmd.res_last  = (cell_ff == AW'(Cells - 1));
   assign cmd.res_index = mm4_pkg::INDEX_W'(cell_ff);
   assign left_addr     = laddr_ff;
   assign right_addr    = raddr_ff;

endmodule

// File: rtl/mm4_dp.sv
// Datapath for the matrix multiplier: operand stores, multiply-accumulate
// pipeline, shift/saturate and result register. Depends on mm4_pkg.
module mm4_dp #(
   parameter int DIM       = mm4_pkg::DIM_DEFAULT,
   parameter int FRAC_BITS = mm4_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        wr_en,
   input  mm4_pkg::req_type            req,
   input  mm4_pkg::cmd_type            cmd,
   input  logic [$clog2(DIM*DIM)-1:0]  left_addr,
   input  logic [$clog2(DIM*DIM)-1:0]  right_addr,
   output mm4_pkg::status_type         status,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output mm4_pkg::rsp_type            rsp
);

   localparam int Cells = DIM * DIM;
   localparam int AW    = $clog2(Cells);
   localparam int EW    = mm4_pkg::ELEM_W;
   localparam int PW    = 2 * EW;
   localparam int AccW  = PW + $clog2(DIM);

   logic signed [EW-1:0] left_mem [Cells];
   logic signed [EW-1:0] right_mem [Cells];

   logic                   store_en;
   logic [AW-1:0]          waddr;

   logic signed [EW-1:0]   left_q_ff, right_q_ff;
   logic                   rd_vld_ff, rd_first_ff, rd_last_ff;
   logic signed [PW-1:0]   prod_ff, prod_in;
   logic                   mul_vld_ff, mul_first_ff, mul_last_ff;
   logic signed [AccW-1:0] acc_ff, acc_in;
   logic                   acc_done_ff;
   logic signed [AccW-1:0] shifted;
   logic [AccW-32:0]       upper;
   logic signed [EW-1:0]   sat_val;
   logic                   rsp_valid_ff;
   mm4_pkg::rsp_type       rsp_ff;

   assign store_en = wr_en && (32'(req.element_index) < Cells);
   assign waddr    = AW'(req.element_index);

   always_ff @(posedge clock) begin
      if (store_en) begin
         left_mem[waddr]  <= req.left_element;
         right_mem[waddr] <= req.right_element;
      end
      left_q_ff  <= left_mem[left_addr];
      right_q_ff <= right_mem[right_addr];
   end

   assign prod_in = left_q_ff * right_q_ff;
   assign acc_in  = mul_first_ff ? AccW'(prod_ff) : acc_ff + AccW'(prod_ff);

   always_ff @(posedge clock) begin
      rd_first_ff  <= cmd.first;
      rd_last_ff   <= cmd.last;
      prod_ff      <= prod_in;
      mul_first_ff <= rd_first_ff;
      mul_last_ff  <= rd_last_ff;
      if (mul_vld_ff) begin
         acc_ff <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff   <= 1'b0;
         mul_vld_ff  <= 1'b0;
         acc_done_ff <= 1'b0;
      end else begin
         rd_vld_ff   <= cmd.issue;
         mul_vld_ff  <= rd_vld_ff;
         acc_done_ff <= mul_vld_ff && mul_last_ff;
      end
   end

   // arithmetic shift rounds toward minus infinity, then clamp to 32 bits
   assign shifted = acc_ff >>> FRAC_BITS;
   assign upper   = shifted[AccW-1:EW-1];
   always_comb begin
      if ((&upper) || !(|upper)) begin
         sat_val = shifted[EW-1:0];
      end else if (acc_ff[AccW-1]) begin
         sat_val = mm4_pkg::SAT_MIN;
      end else begin
         sat_val = mm4_pkg::SAT_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (acc_done_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (acc_done_ff) begin
         rsp_ff.product_element <= sat_val;
         rsp_ff.product_index   <= cmd.res_index;
         rsp_ff.run_last        <= cmd.res_last;
      end
   end

   assign status.out_busy   = rsp_valid_ff;
   assign status.res_loaded = acc_done_ff;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp               = rsp_ff;

endmodule

// File: rtl/matrix_multiply_4x4_top.sv
// Column-major DIM x DIM signed fixed-point matrix multiplier: loads one
// element pair per request, then streams the DIM*DIM saturated results. Loads are
// taken one per cycle while no run is in progress; a request marked last starts a
// run and the input stalls until the final result has been handed to the output
// register. For each result, one multiply-accumulate unit fed by the single read port
// of each operand store does DIM products, followed by pipeline drain and the output
// handover. The operand stores need no clearing after reset.
// Depends on mm4_pkg, mm4_ctrl and mm4_dp.
module matrix_multiply_4x4_top #(
   parameter int DIM       = mm4_pkg::DIM_DEFAULT,
   parameter int FRAC_BITS = mm4_pkg::FRAC_BITS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  mm4_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output mm4_pkg::rsp_type rsp_payload
);

   localparam int AW = $clog2(DIM * DIM);

   logic                busy;
   logic                req_accept;
   mm4_pkg::cmd_type    cmd;
   mm4_pkg::status_type status;
   logic [AW-1:0]       left_addr;
   logic [AW-1:0]       right_addr;

   assign req_stall  = busy;
   assign req_accept = req_valid && !busy;

   mm4_ctrl #(
      .DIM (DIM)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (req_accept && req_payload.load_last),
      .status     (status),
      .busy       (busy),
      .cmd        (cmd),
      .left_addr  (left_addr),
      .right_addr (right_addr)
   );

   mm4_dp #(
      .DIM       (DIM),
      .FRAC_BITS (FRAC_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (req_accept),
      .req        (req_payload),
      .cmd        (cmd),
      .left_addr  (left_addr),
      .right_addr (right_addr),
      .status     (status),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp        (rsp_payload)
   );

`ifndef ASSERT_OFF
   // a result only ever lands in an empty output register
   a_load_into_empty: assert property (@(posedge clock) disable iff (reset)
      status.res_loaded |-> !status.out_busy)
      else $error("result loaded over a pending response");

   // operand reads for one cell come as a single burst
   a_issue_burst: assert property (@(posedge clock) disable iff (reset)
      (cmd.issue && cmd.last) |=> !cmd.issue)
      else $error("issue continued past last operand");

   // nothing follows the final result of a run without a new run
   a_run_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_payload.run_last) |=> !rsp_valid)
      else $error("response after end of run");
`endif

endmodule

// File: dv/tb.sv
// Self-checking bench for matrix_multiply_4x4_top: loads element pairs, mirrors the operand
// stores and checks every streamed product element in order against its own prediction.
// Depends on mm4_pkg and the RTL under rtl/.
module tb;
   import mm4_pkg::*;

   localparam int DIM          = DIM_DEFAULT;
   localparam int FRAC_BITS    = FRAC_BITS_DEFAULT;
   localparam int CELLS        = DIM * DIM;
   localparam int DRAIN_CYCLES = 40;

   logic    clock;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall   = 1'b0;
   rsp_type rsp_payload;

   logic signed [ELEM_W-1:0] left_mirror [CELLS];
   logic signed [ELEM_W-1:0] right_mirror [CELLS];
   rsp_type expected_products [$];
   int mismatch_count  = 0;
   int rsp_hold_cycles = 0;
   int stall_run_left  = 0;
   bit idle_enable     = 1'b1;

   matrix_multiply_4x4_top #(
      .DIM       (DIM),
      .FRAC_BITS (FRAC_BITS)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("tb failed");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      if (!idle_enable) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic signed [ELEM_W-1:0] rand_element();
      int v;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: begin
            v = $urandom_range(0, 524288);
            return ELEM_W'(v - 262144);
         end
         4, 5, 6: return $urandom;
         7: begin
            case ($urandom_range(0, 4))
               0: return SAT_MIN;
               1: return SAT_MAX;
               2: return '0;
               3: return -1;
               default: return 1;
            endcase
         end
         default: begin
            v = $urandom_range(1, 3) * 65536 + $urandom_range(0, 255) - 128;
            return ($urandom_range(0, 1) == 1) ? ELEM_W'(-v) : ELEM_W'(v);
         end
      endcase
   endfunction

   // drive one request, wait for acceptance, update the mirror, predict a run on load_last, then idle a random gap
   task automatic send_request(input req_type item);
      int gap, row, col, e;
      logic signed [127:0] acc;
      rsp_type product;
      req_payload <= item;
      req_valid   <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      left_mirror[item.element_index]  = item.left_element;
      right_mirror[item.element_index] = item.right_element;
      if (item.load_last) begin
         for (col = 0; col < DIM; col++) begin
            for (row = 0; row < DIM; row++) begin
               acc = '0;
               for (e = 0; e < DIM; e++)
                  acc = acc + left_mirror[row + e * DIM] * right_mirror[e + col * DIM];
               acc = acc >>> FRAC_BITS;
               if (acc > SAT_MAX) product.product_element = SAT_MAX;
               else if (acc < SAT_MIN) product.product_element = SAT_MIN;
               else product.product_element = acc[ELEM_W-1:0];
               product.product_index = INDEX_W'(row + col * DIM);
               product.run_last      = (row + col * DIM == CELLS - 1);
               expected_products.push_back(product);
            end
         end
      end
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (expected_products.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // result receiver: random stall bursts, or a counted hold-off when requested
   always @(posedge clock) begin
      if (rsp_hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         rsp_hold_cycles--;
      end else if (!idle_enable) begin
         rsp_stall <= 1'b0;
      end else if (stall_run_left > 0) begin
         stall_run_left--;
      end else if ($urandom_range(0, 2) == 0) begin
         rsp_stall      <= 1'b1;
         stall_run_left = pick_gap();
      end else begin
         rsp_stall      <= 1'b0;
         stall_run_left = $urandom_range(0, 8);
      end
   end

   always @(posedge clock) begin : check_products
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_products.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, rsp_payload);
            mismatch_count++;
         end else begin
            want = expected_products.pop_front();
            if (rsp_payload.product_element !== want.product_element) begin
               $display("%0t: product_element expected %h actual %h", $time,
                        want.product_element, rsp_payload.product_element);
               mismatch_count++;
            end
            if (rsp_payload.product_index !== want.product_index) begin
               $display("%0t: product_index expected %0d actual %0d", $time,
                        want.product_index, rsp_payload.product_index);
               mismatch_count++;
            end
            if (rsp_payload.run_last !== want.run_last) begin
               $display("%0t: run_last expected %0b actual %0b", $time,
                        want.run_last, rsp_payload.run_last);
               mismatch_count++;
            end
         end
      end
   end

   // full load of extremes: columns saturate low, saturate high, zero, exact
   task automatic test_saturation_load();
      req_type item;
      int i;
      for (i = 0; i < CELLS; i++) begin
         item.left_element = SAT_MIN;
         case (i / DIM)
            0: item.right_element = SAT_MAX;
            1: item.right_element = SAT_MIN;
            2: item.right_element = '0;
            default: item.right_element = (i % DIM == 0) ? -1 : 1;
         endcase
         item.element_index = INDEX_W'(i);
         item.load_last     = (i == CELLS - 1);
         send_request(item);
      end
   endtask

   // loads without last write only; the final request starts a run
   task automatic test_partial_updates();
      send_request('{SAT_MAX, SAT_MIN, INDEX_W'(0), 1'b0});
      send_request('{32'sd0, -32'sd1, INDEX_W'(CELLS - 1), 1'b0});
      send_request('{-32'sd1, 32'sd1, INDEX_W'(5), 1'b0});
      send_request('{32'sh0001_0000, 32'sh0001_0000, INDEX_W'(10), 1'b1});
   endtask

   task automatic test_back_to_back();
      req_type item;
      int n, i;
      idle_enable = 1'b0;
      for (n = 0; n < 2; n++) begin
         for (i = CELLS - 1; i >= 0; i--) begin
            item = '{rand_element(), rand_element(), INDEX_W'(i), i == 0};
            send_request(item);
         end
      end
      idle_enable = 1'b1;
   endtask

   // receiver holds off while the loads for several runs wait behind it
   task automatic test_output_backpressure();
      req_type item;
      int n, i;
      rsp_hold_cycles = 300;
      for (n = 0; n < 4; n++) begin
         for (i = 0; i < 3; i++) begin
            item = '{rand_element(), rand_element(), INDEX_W'($urandom_range(0, CELLS - 1)),
                     i == 2};
            send_request(item);
         end
      end
   endtask

   task automatic test_random_runs(input int count);
      req_type item;
      int sent, shape, n, i, j, tmp;
      int order [CELLS];
      sent = 0;
      while (sent < count) begin
         shape = $urandom_range(0, 99);
         if (shape < 10) begin
            for (i = 0; i < CELLS; i++) order[i] = i;
            for (i = CELLS - 1; i > 0; i--) begin
               j = $urandom_range(0, i);
               tmp = order[i];
               order[i] = order[j];
               order[j] = tmp;
            end
            n = CELLS;
         end else begin
            n = (shape < 75) ? $urandom_range(1, 6) :
                (shape < 90) ? $urandom_range(7, CELLS) : $urandom_range(1, 5);
            for (i = 0; i < n; i++) order[i] = $urandom_range(0, CELLS - 1);
         end
         for (i = 0; i < n; i++) begin
            item = '{rand_element(), rand_element(), INDEX_W'(order[i]),
                     (shape < 90) && (i == n - 1)};
            send_request(item);
            sent++;
         end
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_saturation_load();
      test_partial_updates();
      wait_for_drain();
      test_back_to_back();
      wait_for_drain();
      test_output_backpressure();
      wait_for_drain();
      test_random_runs(390);
      wait_for_drain();
      if (mismatch_count == 0 && expected_products.size() == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule
